/* rtl/core/ptvw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvw_pkg
// shared widths, register indexes and merge unit types for the planar text
// video memory write core
// ----------------------------------------------------------------------------
package ptvw_pkg;

  localparam int unsigned PLANE_BYTES_DEF = 131072;
  localparam int unsigned LINE_BYTES_DEF  = 128;

  localparam int unsigned PLANES      = 4;
  localparam int unsigned PLANE_SEL_W = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_W      = 19;
  localparam int unsigned OFFSET_IN_W = 17;
  localparam int unsigned ROW_W       = PLANES * BYTE_W;
  localparam int unsigned PIX_ROW_W   = 32;
  localparam int unsigned LINE_W      = 10;
  localparam int unsigned COL_OUT_W   = 7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_SIMUL      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_EN    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_EN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_EVEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_ODD   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y   = 3'd5;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] mask;
  } merge_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] new_byte;
    logic              changed;
  } merge_rsp_t;

endpackage

/* rtl/core/ptvw_byte_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvw_byte_merge
// shared masked byte merge and change compare, used once per plane
// ----------------------------------------------------------------------------
module ptvw_byte_merge (
  input  ptvw_pkg::merge_req_t req_i,
  output ptvw_pkg::merge_rsp_t rsp_o
);
  import ptvw_pkg::*;

  logic [BYTE_W-1:0] merged;

  always_comb begin
    merged          = (req_i.old_byte & req_i.mask) | (req_i.wr_byte & ~req_i.mask);
    rsp_o.new_byte  = req_i.en ? merged : req_i.old_byte;
    rsp_o.changed   = req_i.en && (merged != req_i.old_byte);
  end

endmodule

/* rtl/core/planar_text_vram_write_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_text_vram_write_core
// four-plane text video memory with masked plane writes and pixel reporting
// ----------------------------------------------------------------------------
// The four planes share one memory row per byte offset, so one read fetches
// all planes of a byte column. After reset the core sweeps the memory to zero,
// one row a cycle, and holds in_stall_o high meanwhile; configuration writes
// are taken at any time. Each transaction then keeps in_stall_o high while it
// runs S_DIV and S_OFS to split the offset from the address, S_LDIV and S_LMOD
// to split line and column while the row is read, four passes of the shared
// byte merge unit in S_MERGE (one plane each) and S_WB, which writes back and
// loads the result register. The result appears at the edge that ends the
// write-back, and the next transaction can be taken in the cycle after that
// edge, so a new transaction is not taken before the last one has written
// back. While the output register still holds a stalled result the write-back
// waits, and in_stall_o stays high for as long.
// ----------------------------------------------------------------------------
module planar_text_vram_write_core #(
  parameter int unsigned PLANE_BYTES = ptvw_pkg::PLANE_BYTES_DEF,
  parameter int unsigned LINE_BYTES  = ptvw_pkg::LINE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ptvw_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [ptvw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_action_i,
  input  logic [ptvw_pkg::ADDR_W-1:0]        in_address_i,
  input  logic [ptvw_pkg::BYTE_W-1:0]        in_write_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ptvw_pkg::BYTE_W-1:0]        out_read_data_o,
  output logic                               out_pixel_valid_o,
  output logic [ptvw_pkg::PIX_ROW_W-1:0]     out_pixel_row_o,
  output logic [ptvw_pkg::LINE_W-1:0]        out_pixel_line_o,
  output logic [ptvw_pkg::COL_OUT_W-1:0]     out_pixel_column_o,
  output logic                               out_line_changed_o,
  output logic [ptvw_pkg::LINE_W-1:0]        out_dirty_line_o
);
  import ptvw_pkg::*;

  localparam int unsigned OFS_W   = $clog2(PLANE_BYTES);
  localparam int unsigned S1      = OFFSET_IN_W + OFS_W;
  localparam int unsigned RCP1_W  = OFFSET_IN_W + 1;
  localparam int unsigned P1_W    = OFFSET_IN_W + RCP1_W;
  localparam int unsigned Q1_W    = OFFSET_IN_W + 1 - OFS_W;
  localparam int unsigned REM1_W  = OFFSET_IN_W + 1;
  localparam longint unsigned R1  = (64'd1 << S1) / 64'(PLANE_BYTES);

  localparam int unsigned COL_W   = $clog2(LINE_BYTES);
  localparam int unsigned S2      = OFS_W + COL_W;
  localparam int unsigned RCP2_W  = OFS_W + 1;
  localparam int unsigned P2_W    = OFS_W + RCP2_W;
  localparam int unsigned Q2_W    = OFS_W + 1 - COL_W;
  localparam int unsigned REM2_W  = OFS_W + 1;
  localparam longint unsigned R2  = (64'd1 << S2) / 64'(LINE_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_OFS   = 8'b0000_1000,
    S_LDIV  = 8'b0001_0000,
    S_LMOD  = 8'b0010_0000,
    S_MERGE = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [OFS_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [1:0]             k_q, k_d;
  logic                   out_valid_q, out_valid_d;

  logic                   simul_q;
  logic                   mask_en_q;
  logic [PLANES-1:0]      plane_en_q;
  logic [BYTE_W-1:0]      mask_even_q;
  logic [BYTE_W-1:0]      mask_odd_q;
  logic [LINE_W-1:0]      scroll_y_q;

  logic                   action_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [BYTE_W-1:0]      wdata_q;
  logic [Q1_W-1:0]        q1_q;
  logic [OFS_W-1:0]       off_q;
  logic [Q2_W-1:0]        q2_q;
  logic [LINE_W-1:0]      line_q;
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       wrow_q;
  logic                   changed_q;

  logic [BYTE_W-1:0]      rd_data_q;
  logic                   pix_valid_q;
  logic [PIX_ROW_W-1:0]   pix_row_q;
  logic [LINE_W-1:0]      pix_line_q;
  logic [COL_OUT_W-1:0]   pix_col_q;
  logic                   line_changed_q;
  logic [LINE_W-1:0]      dirty_line_q;

  logic [ROW_W-1:0]       vram_q [PLANE_BYTES];
  logic [ROW_W-1:0]       mem_rdata_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [OFS_W-1:0]       mem_waddr;
  logic [ROW_W-1:0]       mem_wdata;

  logic                   in_accept;
  logic                   wb_go;
  logic [P1_W-1:0]        prod1;
  logic [Q1_W-1:0]        q1_d;
  logic [REM1_W-1:0]      rem1;
  logic [REM1_W-1:0]      rem1_fix;
  logic [P2_W-1:0]        prod2;
  logic [Q2_W-1:0]        q2_d;
  logic [REM2_W-1:0]      rem2;
  logic [REM2_W-1:0]      rem2_fix;
  logic [Q2_W-1:0]        q2_fix;
  logic [PLANES-1:0]      plane_wr;
  logic [BYTE_W-1:0]      wr_mask;
  logic [PLANE_SEL_W-1:0] plane_sel;
  logic [PIX_ROW_W-1:0]   pix_row;
  merge_req_t             merge_req;
  merge_rsp_t             merge_rsp;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign wb_go = (state_q == S_WB) && (!out_valid_q || !out_stall_i);
  assign plane_sel = addr_q[ADDR_W-1 -: PLANE_SEL_W];

  // offset within a plane
  always_comb begin
    prod1    = P1_W'(addr_q[OFFSET_IN_W-1:0]) * P1_W'(R1);
    q1_d     = Q1_W'(prod1 >> S1);
    rem1     = REM1_W'(addr_q[OFFSET_IN_W-1:0]) - REM1_W'(q1_q) * REM1_W'(PLANE_BYTES);
    rem1_fix = (rem1 >= REM1_W'(PLANE_BYTES)) ? rem1 - REM1_W'(PLANE_BYTES) : rem1;
  end

  // line and column of the offset
  always_comb begin
    prod2 = P2_W'(off_q) * P2_W'(R2);
    q2_d  = Q2_W'(prod2 >> S2);
    rem2  = REM2_W'(off_q) - REM2_W'(q2_q) * REM2_W'(LINE_BYTES);
    if (rem2 >= REM2_W'(LINE_BYTES)) begin
      rem2_fix = rem2 - REM2_W'(LINE_BYTES);
      q2_fix   = q2_q + Q2_W'(1);
    end else begin
      rem2_fix = rem2;
      q2_fix   = q2_q;
    end
  end

  always_comb begin
    for (int k = 0; k < PLANES; k++) begin
      plane_wr[k] = action_q && (simul_q ? plane_en_q[k]
                                         : (plane_sel == PLANE_SEL_W'(k)));
    end
    wr_mask = mask_en_q ? (addr_q[0] ? mask_odd_q : mask_even_q) : '0;
  end

  always_comb begin
    merge_req.en       = plane_wr[k_q];
    merge_req.old_byte = wrow_q[BYTE_W*k_q +: BYTE_W];
    merge_req.wr_byte  = wdata_q;
    merge_req.mask     = wr_mask;
  end

  ptvw_byte_merge u_merge (
    .req_i (merge_req),
    .rsp_o (merge_rsp)
  );

  // chunky pixel j takes bit 7-j of each plane
  always_comb begin
    for (int j = 0; j < BYTE_W; j++) begin
      for (int k = 0; k < PLANES; k++) begin
        pix_row[PLANES*j + k] = wrow_q[BYTE_W*k + (BYTE_W - 1 - j)];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + OFS_W'(1);
        if (clr_cnt_q == OFS_W'(PLANE_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DIV;
        end
      end
      S_DIV:  state_d = S_OFS;
      S_OFS:  state_d = S_LDIV;
      S_LDIV: state_d = S_LMOD;
      S_LMOD: begin
        k_d     = 2'd0;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (wb_go) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      simul_q     <= 1'b0;
      mask_en_q   <= 1'b0;
      plane_en_q  <= '0;
      mask_even_q <= '0;
      mask_odd_q  <= '0;
      scroll_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIMUL:     simul_q     <= cfg_data_i[0];
        CFG_MASK_EN:   mask_en_q   <= cfg_data_i[0];
        CFG_PLANE_EN:  plane_en_q  <= cfg_data_i[PLANES-1:0];
        CFG_MASK_EVEN: mask_even_q <= cfg_data_i[BYTE_W-1:0];
        CFG_MASK_ODD:  mask_odd_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_SCROLL_Y:  scroll_y_q  <= cfg_data_i[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= in_action_i;
      addr_q   <= in_address_i;
      wdata_q  <= in_write_data_i;
    end
    if (state_q == S_DIV) begin
      q1_q <= q1_d;
    end
    if (state_q == S_OFS) begin
      off_q <= OFS_W'(rem1_fix);
    end
    if (state_q == S_LDIV) begin
      q2_q <= q2_d;
    end
    if (state_q == S_LMOD) begin
      line_q    <= LINE_W'(q2_fix);
      col_q     <= COL_W'(rem2_fix);
      wrow_q    <= mem_rdata_q;
      changed_q <= 1'b0;
    end
    if (state_q == S_MERGE) begin
      wrow_q[BYTE_W*k_q +: BYTE_W] <= merge_rsp.new_byte;
      changed_q <= changed_q || merge_rsp.changed;
    end
    if (wb_go) begin
      rd_data_q      <= action_q ? '0 : wrow_q[BYTE_W*plane_sel +: BYTE_W];
      pix_valid_q    <= action_q;
      pix_row_q      <= action_q ? pix_row : '0;
      pix_line_q     <= action_q ? line_q : '0;
      pix_col_q      <= action_q ? COL_OUT_W'(col_q) : '0;
      line_changed_q <= action_q && changed_q;
      dirty_line_q   <= action_q ? (line_q - scroll_y_q) : '0;
    end
  end

  // row memory, all four planes of one offset per row
  always_comb begin
    mem_we    = (state_q == S_CLEAR) || (wb_go && action_q);
    mem_re    = (state_q == S_LDIV);
    mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : off_q;
    mem_wdata = (state_q == S_CLEAR) ? '0 : wrow_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vram_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= vram_q[off_q];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_read_data_o    = rd_data_q;
  assign out_pixel_valid_o  = pix_valid_q;
  assign out_pixel_row_o    = pix_row_q;
  assign out_pixel_line_o   = pix_line_q;
  assign out_pixel_column_o = pix_col_q;
  assign out_line_changed_o = line_changed_q;
  assign out_dirty_line_o   = dirty_line_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_DIV))
    else $error("accepted transaction did not start the sequence");

  a_merge_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE && k_q == 2'd3) |=> (state_q == S_WB))
    else $error("merge did not end after four planes");

  a_wb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go |=> (out_valid_q && state_q == S_IDLE))
    else $error("write-back did not present a result");

  a_read_no_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pix_valid_q) |-> (pix_row_q == '0 && !line_changed_q))
    else $error("read transaction reported pixel data");
`endif

endmodule

/* test/planar_text_vram_write_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_text_vram_write_core_test
// self-checking bench for the planar text video memory write core: directed
// reads, single-plane, masked and simultaneous writes and scrolled dirty lines,
// then random traffic over a small set of hot offsets under changing register
// settings, with bursty input and a random or periodic output stall. every result is
// compared field by field against a predictor holding its own copy of memory
// ----------------------------------------------------------------------------
module planar_text_vram_write_core_test;
  import ptvw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOT_OFFSETS  = 8;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 115;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    read_data;
    logic                 pixel_valid;
    logic [PIX_ROW_W-1:0] pixel_row;
    logic [LINE_W-1:0]    pixel_line;
    logic [COL_OUT_W-1:0] pixel_column;
    logic                 line_changed;
    logic [LINE_W-1:0]    dirty_line;
  } vram_result_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  logic                   in_action_i     = 1'b0;
  logic [ADDR_W-1:0]      in_address_i    = '0;
  logic [BYTE_W-1:0]      in_write_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  logic [BYTE_W-1:0]      out_read_data_o;
  logic                   out_pixel_valid_o;
  logic [PIX_ROW_W-1:0]   out_pixel_row_o;
  logic [LINE_W-1:0]      out_pixel_line_o;
  logic [COL_OUT_W-1:0]   out_pixel_column_o;
  logic                   out_line_changed_o;
  logic [LINE_W-1:0]      out_dirty_line_o;

  bit [BYTE_W-1:0]  vram_model [PLANES][PLANE_BYTES_DEF];
  bit               sim_en_q;
  bit               mask_en_q;
  bit [PLANES-1:0]  plane_en_q;
  bit [BYTE_W-1:0]  mask_even_q;
  bit [BYTE_W-1:0]  mask_odd_q;
  bit [LINE_W-1:0]  scroll_q;

  vram_result_t     pending_results [$];
  int unsigned      errors     = 0;
  int unsigned      cycles     = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_max    = 3;
  stall_mode_t      stall_mode = STALL_NONE;
  int unsigned      stall_run  = 0;

  planar_text_vram_write_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_action_i        (in_action_i),
    .in_address_i       (in_address_i),
    .in_write_data_i    (in_write_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_read_data_o    (out_read_data_o),
    .out_pixel_valid_o  (out_pixel_valid_o),
    .out_pixel_row_o    (out_pixel_row_o),
    .out_pixel_line_o   (out_pixel_line_o),
    .out_pixel_column_o (out_pixel_column_o),
    .out_line_changed_o (out_line_changed_o),
    .out_dirty_line_o   (out_dirty_line_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall_i <= stall_run[2];
      default:        out_stall_i <= 1'b0;
    endcase
  end

  function automatic vram_result_t predict_access(access_t act, logic [ADDR_W-1:0] addr,
                                                  logic [BYTE_W-1:0] wd);
    vram_result_t           res;
    logic [PLANE_SEL_W-1:0] plane;
    logic [OFFSET_IN_W-1:0] off;
    logic [BYTE_W-1:0]      mask;
    logic [BYTE_W-1:0]      merged;
    logic [PLANES-1:0]      targets;
    res   = '0;
    plane = addr[ADDR_W-1 -: PLANE_SEL_W];
    off   = addr[OFFSET_IN_W-1:0];
    if (act == ACC_READ) begin
      res.read_data = vram_model[plane][off];
      return res;
    end
    mask = mask_en_q ? (addr[0] ? mask_odd_q : mask_even_q) : '0;
    if (sim_en_q) begin
      targets = plane_en_q;
    end else begin
      targets        = '0;
      targets[plane] = 1'b1;
    end
    for (int k = 0; k < PLANES; k++) begin
      if (targets[k]) begin
        merged = (vram_model[k][off] & mask) | (wd & ~mask);
        if (merged != vram_model[k][off]) begin
          res.line_changed  = 1'b1;
          vram_model[k][off] = merged;
        end
      end
    end
    for (int j = 0; j < BYTE_W; j++)
      for (int k = 0; k < PLANES; k++)
        res.pixel_row[4*j+k] = vram_model[k][off][BYTE_W-1-j];
    res.pixel_valid  = 1'b1;
    res.pixel_line   = off[OFFSET_IN_W-1 -: LINE_W];
    res.pixel_column = off[COL_OUT_W-1:0];
    res.dirty_line   = res.pixel_line - scroll_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    vram_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, expected none, actual 0x%0h",
                 $time, out_pixel_row_o);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_read_data_o);
        check_field("pixel_valid", want.pixel_valid, out_pixel_valid_o);
        check_field("pixel_row", want.pixel_row, out_pixel_row_o);
        check_field("pixel_line", want.pixel_line, out_pixel_line_o);
        check_field("pixel_column", want.pixel_column, out_pixel_column_o);
        check_field("line_changed", want.line_changed, out_line_changed_o);
        check_field("dirty_line", want.dirty_line, out_dirty_line_o);
      end
    end
  end

  task automatic send_access(access_t act, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] wd);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    in_action_i     <= act;
    in_address_i    <= addr;
    in_write_data_i <= wd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    pending_results.push_back(predict_access(act, addr, wd));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           int unsigned width);
    logic [CFG_DATA_W-1:0] data;
    data = value;
    if (width < CFG_DATA_W) data = data | (CFG_DATA_W'($urandom) << width);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SIMUL:     sim_en_q    = data[0];
      CFG_MASK_EN:   mask_en_q   = data[0];
      CFG_PLANE_EN:  plane_en_q  = data[PLANES-1:0];
      CFG_MASK_EVEN: mask_even_q = data[BYTE_W-1:0];
      CFG_MASK_ODD:  mask_odd_q  = data[BYTE_W-1:0];
      CFG_SCROLL_Y:  scroll_q    = data[LINE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(bit sim, bit men, logic [PLANES-1:0] pen,
                              logic [BYTE_W-1:0] mev, logic [BYTE_W-1:0] mod,
                              logic [LINE_W-1:0] scr);
    write_reg(CFG_SIMUL, CFG_DATA_W'(sim), 1);
    write_reg(CFG_MASK_EN, CFG_DATA_W'(men), 1);
    write_reg(CFG_PLANE_EN, CFG_DATA_W'(pen), PLANES);
    write_reg(CFG_MASK_EVEN, CFG_DATA_W'(mev), BYTE_W);
    write_reg(CFG_MASK_ODD, CFG_DATA_W'(mod), BYTE_W);
    write_reg(CFG_SCROLL_Y, CFG_DATA_W'(scr), LINE_W);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                CFG_DATA_W'($urandom), CFG_DATA_W);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_single_plane();
    send_access(ACC_READ,  19'h00000, 8'hff);
    send_access(ACC_WRITE, 19'h7ffff, 8'hff);
    send_access(ACC_READ,  19'h7ffff, 8'h00);
    send_access(ACC_WRITE, 19'h7ffff, 8'hff);
    send_access(ACC_WRITE, 19'h00000, 8'h80);
    send_access(ACC_WRITE, 19'h20000, 8'h01);
    send_access(ACC_WRITE, 19'h40000, 8'ha5);
    send_access(ACC_READ,  19'h40000, 8'h5a);
    drain_results();
  endtask

  task automatic test_write_mask();
    apply_config(1'b0, 1'b1, 4'h0, 8'hf0, 8'h0f, 10'd0);
    send_access(ACC_WRITE, 19'h00010, 8'hff);
    send_access(ACC_WRITE, 19'h00011, 8'hff);
    send_access(ACC_READ,  19'h00010, 8'h00);
    send_access(ACC_READ,  19'h00011, 8'h00);
    drain_results();
    apply_config(1'b0, 1'b1, 4'h0, 8'hff, 8'h00, 10'd0);
    send_access(ACC_WRITE, 19'h00010, 8'h00);
    send_access(ACC_WRITE, 19'h00011, 8'h00);
    drain_results();
  endtask

  task automatic test_simultaneous();
    apply_config(1'b1, 1'b0, 4'h0, 8'h00, 8'h00, 10'd0);
    send_access(ACC_WRITE, 19'h60123, 8'hff);
    drain_results();
    apply_config(1'b1, 1'b0, 4'hf, 8'h00, 8'h00, 10'd0);
    send_access(ACC_WRITE, 19'h00123, 8'h5a);
    send_access(ACC_READ,  19'h60123, 8'h00);
    drain_results();
    apply_config(1'b1, 1'b0, 4'h5, 8'h00, 8'h00, 10'd0);
    send_access(ACC_WRITE, 19'h20123, 8'hc3);
    send_access(ACC_READ,  19'h20123, 8'h00);
    drain_results();
  endtask

  task automatic test_scroll();
    apply_config(1'b0, 1'b0, 4'h0, 8'h00, 8'h00, 10'd1023);
    send_access(ACC_WRITE, 19'h00000, 8'h55);
    send_access(ACC_WRITE, 19'h1ff80, 8'h3c);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [OFFSET_IN_W-1:0] hot [HOT_OFFSETS];
    logic [ADDR_W-1:0]      addr;
    logic [BYTE_W-1:0]      mev;
    logic [BYTE_W-1:0]      mod;
    logic [LINE_W-1:0]      scr;
    access_t                act;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        apply_config(1'b0, 1'b0, 4'h0, 8'h00, 8'h00, 10'd0);
      end else if (p == 1) begin
        apply_config(1'b1, 1'b1, 4'hf, 8'hff, 8'hff, 10'd1023);
      end else begin
        mev = BYTE_W'($urandom);
        if ($urandom_range(0, 4) == 0) mev = $urandom_range(0, 1) ? 8'hff : 8'h00;
        mod = BYTE_W'($urandom);
        if ($urandom_range(0, 4) == 0) mod = $urandom_range(0, 1) ? 8'hff : 8'h00;
        case ($urandom_range(0, 3))
          0:       scr = '0;
          1:       scr = '1;
          default: scr = LINE_W'($urandom);
        endcase
        apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     PLANES'($urandom), mev, mod, scr);
      end
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
      hot[0] = '0;
      hot[1] = '1;
      for (int h = 2; h < HOT_OFFSETS; h++) hot[h] = OFFSET_IN_W'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7)
          addr = {PLANE_SEL_W'($urandom), hot[$urandom_range(0, HOT_OFFSETS-1)]};
        else
          addr = ADDR_W'($urandom);
        act = ($urandom_range(0, 9) < 6) ? ACC_WRITE : ACC_READ;
        send_access(act, addr, BYTE_W'($urandom));
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_plane();
    test_write_mask();
    test_simultaneous();
    test_scroll();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* planar_text_vram_write_core.f */
rtl/core/ptvw_pkg.sv
rtl/core/ptvw_byte_merge.sv
rtl/core/planar_text_vram_write_core.sv
test/planar_text_vram_write_core_test.sv
